@@ design/rcfr_pkg.sv @@
// rcfr_pkg: shared types and constants of the radio control frame receiver
// used by rcfr_front, rcfr_back and radio_control_frame_receiver
package rcfr_pkg;

  localparam int RcFrameLen = 7;
  localparam logic [7:0] RC_STOP_BYTE = 8'd254;
  localparam logic [14:0] RC_THR_BASE = 15'd1000;
  localparam logic [14:0] RC_THR_SCALE = 15'd100;
  localparam int RcQueueDepth = 4;
  localparam int RcCfgIndexW = 4;
  localparam int RcCfgDataW = 16;

  // request kinds handed from front to back
  localparam logic [1:0] EV_BAD_LEN = 2'd0;
  localparam logic [1:0] EV_FRAME = 2'd1;
  localparam logic [1:0] EV_OVERRUN = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_LEN = 3'd1;
  localparam logic [2:0] ST_CHECKSUM = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_OVERRUN = 3'd4;

  // register indexes
  localparam logic [RcCfgIndexW-1:0] REG_ROLL_MIN = 4'd0;
  localparam logic [RcCfgIndexW-1:0] REG_ROLL_MAX = 4'd1;
  localparam logic [RcCfgIndexW-1:0] REG_PITCH_MIN = 4'd2;
  localparam logic [RcCfgIndexW-1:0] REG_PITCH_MAX = 4'd3;
  localparam logic [RcCfgIndexW-1:0] REG_THROTTLE_MIN = 4'd4;
  localparam logic [RcCfgIndexW-1:0] REG_THROTTLE_MAX = 4'd5;
  localparam logic [RcCfgIndexW-1:0] REG_YAW_MIN = 4'd6;
  localparam logic [RcCfgIndexW-1:0] REG_YAW_MAX = 4'd7;

  typedef logic [RcFrameLen-1:0][7:0] frame_t;

  typedef struct packed {
    logic [1:0] kind;
    frame_t     frame;
  } rc_event_t;

  typedef struct packed {
    logic signed [7:0]  roll_min;
    logic signed [7:0]  roll_max;
    logic signed [7:0]  pitch_min;
    logic signed [7:0]  pitch_max;
    logic [14:0]        throttle_min;
    logic [14:0]        throttle_max;
    logic signed [15:0] yaw_min;
    logic signed [15:0] yaw_max;
  } rc_limits_t;

endpackage

@@ design/rcfr_front.sv @@
// rcfr_front: gathers received bytes into a frame and classifies each byte
// depends on rcfr_pkg; feeds the request queue in the top level
module rcfr_front import rcfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       push,
  output rc_event_t  push_event
);

  frame_t     frame;
  logic [2:0] byte_count;
  logic       is_stop;
  logic       full;

  assign is_stop = (rx_byte == RC_STOP_BYTE);
  assign full = (byte_count == 3'(RcFrameLen));

  assign push = accept && (is_stop || full);

  always_comb begin
    push_event.frame = frame;
    if (!is_stop) begin
      push_event.kind = EV_OVERRUN;
    end else if (full) begin
      push_event.kind = EV_FRAME;
    end else begin
      push_event.kind = EV_BAD_LEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      if (is_stop) begin
        byte_count <= '0;
      end else if (!full) begin
        byte_count <= byte_count + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_stop && !full) begin
      frame[byte_count] <= rx_byte;
    end
  end

endmodule

@@ design/rcfr_back.sv @@
// rcfr_back: checks and decodes frame requests, keeps the held channels
// depends on rcfr_pkg; holds the result register behind the top-level outputs
module rcfr_back import rcfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  rc_event_t          q_event,
  output logic               q_pop,
  input  rc_limits_t         limits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [7:0]  roll_out,
  output logic signed [7:0]  pitch_out,
  output logic [14:0]        throttle_out,
  output logic signed [15:0] yaw_out
);

  logic signed [7:0]  roll_held;
  logic signed [7:0]  pitch_held;
  logic [14:0]        throttle_held;
  logic signed [15:0] yaw_held;

  logic [7:0]         sum;
  logic [14:0]        thr;
  logic signed [7:0]  pit;
  logic signed [7:0]  rol;
  logic signed [16:0] yaw_wide;
  logic signed [15:0] yaw;
  logic               chans_ok;
  logic [2:0]         status_next;

  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    sum = '0;
    for (int i = 0; i < RcFrameLen - 1; i++) begin
      sum = 8'((sum + q_event.frame[i]) << 1);
    end
  end

  assign thr = RC_THR_BASE + 15'(q_event.frame[0]) * RC_THR_SCALE + 15'(q_event.frame[1]);
  assign pit = $signed(q_event.frame[2]);
  assign rol = $signed(q_event.frame[3]);
  assign yaw_wide = $signed({1'b0, q_event.frame[5]}) * $signed(q_event.frame[4]);
  assign yaw = yaw_wide[15:0];

  assign chans_ok = (pit >= limits.pitch_min) && (pit <= limits.pitch_max) &&
                    (rol >= limits.roll_min) && (rol <= limits.roll_max) &&
                    (thr >= limits.throttle_min) && (thr <= limits.throttle_max) &&
                    (yaw >= limits.yaw_min) && (yaw <= limits.yaw_max);

  always_comb begin
    unique case (q_event.kind)
      EV_BAD_LEN: status_next = ST_BAD_LEN;
      EV_OVERRUN: status_next = ST_OVERRUN;
      EV_FRAME: begin
        if (sum != q_event.frame[6]) begin
          status_next = ST_CHECKSUM;
        end else if (!chans_ok) begin
          status_next = ST_RANGE;
        end else begin
          status_next = ST_OK;
        end
      end
      default: status_next = ST_BAD_LEN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      roll_held <= '0;
      pitch_held <= '0;
      throttle_held <= '0;
      yaw_held <= '0;
    end else begin
      if (q_pop) begin
        out_valid <= 1'b1;
        if (status_next == ST_OK) begin
          roll_held <= rol;
          pitch_held <= pit;
          throttle_held <= thr;
          yaw_held <= yaw;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status <= status_next;
      if (status_next == ST_OK) begin
        roll_out <= rol;
        pitch_out <= pit;
        throttle_out <= thr;
        yaw_out <= yaw;
      end else begin
        roll_out <= roll_held;
        pitch_out <= pitch_held;
        throttle_out <= throttle_held;
        yaw_out <= yaw_held;
      end
    end
  end

endmodule

@@ design/radio_control_frame_receiver.sv @@
// radio_control_frame_receiver: top level with limit registers and request queue
// depends on rcfr_pkg, rcfr_front and rcfr_back
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   in       | in_valid / in_stall     | rx_byte
//   out      | out_valid / out_stall   | status, roll_out, pitch_out, throttle_out,
//            |                         | yaw_out
//   cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one byte per cycle while in_stall is low; a stop byte or overrun byte has its
// result valid after the 4-entry request queue and the result register.
// in_stall rises only when the request queue is full while out_stall is held.
// synchronous reset restores the limit registers and clears the held channels.
// cfg_ready is always high.
module radio_control_frame_receiver import rcfr_pkg::*; #(
  parameter int QueueDepth = RcQueueDepth
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             status,
  output logic signed [7:0]      roll_out,
  output logic signed [7:0]      pitch_out,
  output logic [14:0]            throttle_out,
  output logic signed [15:0]     yaw_out,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [RcCfgIndexW-1:0] cfg_index,
  input  logic [RcCfgDataW-1:0]  cfg_data
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  rc_limits_t limits;
  rc_event_t  queue [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  logic      accept;
  logic      push;
  rc_event_t push_event;
  logic      q_valid;
  logic      q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall = (count == CntW'(QueueDepth));
  assign accept = in_valid && !in_stall;
  assign q_valid = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.roll_min <= -8'sd45;
      limits.roll_max <= 8'sd45;
      limits.pitch_min <= -8'sd45;
      limits.pitch_max <= 8'sd45;
      limits.throttle_min <= 15'd1000;
      limits.throttle_max <= 15'd1900;
      limits.yaw_min <= -16'sd180;
      limits.yaw_max <= 16'sd180;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROLL_MIN: limits.roll_min <= cfg_data[7:0];
        REG_ROLL_MAX: limits.roll_max <= cfg_data[7:0];
        REG_PITCH_MIN: limits.pitch_min <= cfg_data[7:0];
        REG_PITCH_MAX: limits.pitch_max <= cfg_data[7:0];
        REG_THROTTLE_MIN: limits.throttle_min <= cfg_data[14:0];
        REG_THROTTLE_MAX: limits.throttle_max <= cfg_data[14:0];
        REG_YAW_MIN: limits.yaw_min <= cfg_data[15:0];
        REG_YAW_MAX: limits.yaw_max <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= push_event;
    end
  end

  rcfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (rx_byte),
    .push       (push),
    .push_event (push_event)
  );

  rcfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_event      (queue[rd_ptr]),
    .q_pop        (q_pop),
    .limits       (limits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .roll_out     (roll_out),
    .pitch_out    (pitch_out),
    .throttle_out (throttle_out),
    .yaw_out      (yaw_out)
  );

endmodule
